/* hdl/assert_macros.svh */
// Assertion macros shared by the frame deframer RTL.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/wsd_pkg.sv */
// Types and constants for the WebSocket frame deframer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXTHI = 3'd2,
        PH_EXTLO = 3'd3,
        PH_MASK  = 3'd4,
        PH_DATA  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam logic ERR_LEN64    = 1'b0;
    localparam logic ERR_OVER_MAX = 1'b1;

    localparam logic [6:0]  LEN_CODE_EXT16    = 7'd126;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;
    localparam logic [15:0] MASK_KEY_BYTES    = 16'd4;

    typedef struct packed {
        logic       valid;
        logic [7:0] wire_byte;
    } in_item_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  data;
        logic [3:0]  frame_opcode;
        logic [15:0] frame_length;
        logic        error_code;
        logic        last;
    } result_t;

endpackage

/* hdl/wsd_in_stage.sv */
// Input register of the frame deframer: holds one received byte until parsed.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_wire_byte,
    input  logic              consume,
    output wsd_pkg::in_item_t item
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;

    // A new byte may enter when the slot is empty or is being parsed this cycle.
    assign s_ready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (s_ready) begin
            valid_next = s_valid;
            if (s_valid) begin
                byte_next = s_wire_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
    end

    assign item.valid     = valid_reg;
    assign item.wire_byte = byte_reg;

endmodule

/* hdl/wsd_parser.sv */
// Header and payload parser: frame state, limit register and unmasking.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              fire,
    input  wsd_pkg::in_item_t item,
    output wsd_pkg::result_t  result
);

    wsd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_on_reg, mask_on_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] key_reg, key_next;
    logic [15:0] max_payload_reg;

    logic [7:0]  b;
    logic [6:0]  len_code;
    logic [15:0] known_len;
    logic        len_over;
    logic [15:0] count_inc;
    logic [7:0]  key_byte;
    logic        data_last;

    assign b         = item.wire_byte;
    assign len_code  = b[6:0];
    assign count_inc = count_reg + 16'd1;
    assign data_last = (count_inc >= length_reg);

    // Length as it becomes known, either from the short code or the 16-bit field.
    always_comb begin
        if (phase_reg == wsd_pkg::PH_EXTLO) begin
            known_len = {length_reg[15:8], b};
        end else begin
            known_len = {9'd0, len_code};
        end
    end

    assign len_over = (known_len > max_payload_reg);

    always_comb begin
        case (count_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        if (!mask_on_reg) begin
            key_byte = 8'd0;
        end
    end

    // Next-state logic.
    always_comb begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        mask_on_next = mask_on_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        if (fire) begin
            case (phase_reg)
                wsd_pkg::PH_HDR1, wsd_pkg::PH_EXTLO: begin
                    if (phase_reg == wsd_pkg::PH_HDR1) begin
                        mask_on_next = b[7];
                    end
                    if (phase_reg == wsd_pkg::PH_HDR1 && len_code == wsd_pkg::LEN_CODE_EXT16) begin
                        phase_next = wsd_pkg::PH_EXTHI;
                    end else if (phase_reg == wsd_pkg::PH_HDR1
                                 && !(len_code inside {[7'd0:7'd125]})) begin
                        length_next = 16'd0;
                        phase_next  = wsd_pkg::PH_HDR0;
                    end else begin
                        length_next = known_len;
                        if (len_over) begin
                            phase_next = wsd_pkg::PH_HDR0;
                        end else begin
                            count_next = 16'd0;
                            if (mask_on_next) begin
                                phase_next = wsd_pkg::PH_MASK;
                            end else if (known_len == 16'd0) begin
                                phase_next = wsd_pkg::PH_HDR0;
                            end else begin
                                phase_next = wsd_pkg::PH_DATA;
                            end
                        end
                    end
                end
                wsd_pkg::PH_EXTHI: begin
                    length_next = {b, 8'd0};
                    phase_next  = wsd_pkg::PH_EXTLO;
                end
                wsd_pkg::PH_MASK: begin
                    key_next = {key_reg[23:0], b};
                    if (count_inc < wsd_pkg::MASK_KEY_BYTES) begin
                        count_next = count_inc;
                    end else begin
                        count_next = 16'd0;
                        phase_next = (length_reg == 16'd0) ? wsd_pkg::PH_HDR0
                                                           : wsd_pkg::PH_DATA;
                    end
                end
                wsd_pkg::PH_DATA: begin
                    count_next = count_inc;
                    if (data_last) begin
                        phase_next = wsd_pkg::PH_HDR0;
                    end
                end
                default: begin
                    // First header byte; unused phase codes land here as well.
                    opcode_next = b[3:0];
                    phase_next  = wsd_pkg::PH_HDR1;
                end
            endcase
        end
    end

    // Result logic.
    always_comb begin
        result.valid        = 1'b0;
        result.kind         = wsd_pkg::KIND_DATA;
        result.data         = 8'd0;
        result.frame_opcode = opcode_reg;
        result.frame_length = 16'd0;
        result.error_code   = wsd_pkg::ERR_LEN64;
        result.last         = 1'b0;
        if (fire) begin
            case (phase_reg)
                wsd_pkg::PH_HDR1, wsd_pkg::PH_EXTLO: begin
                    if (phase_reg == wsd_pkg::PH_HDR1 && len_code == wsd_pkg::LEN_CODE_EXT16) begin
                        result.valid = 1'b0;
                    end else if (phase_reg == wsd_pkg::PH_HDR1
                                 && !(len_code inside {[7'd0:7'd125]})) begin
                        result.valid = 1'b1;
                        result.kind  = wsd_pkg::KIND_ERROR;
                        result.last  = 1'b1;
                    end else if (len_over) begin
                        result.valid        = 1'b1;
                        result.kind         = wsd_pkg::KIND_ERROR;
                        result.frame_length = known_len;
                        result.error_code   = wsd_pkg::ERR_OVER_MAX;
                        result.last         = 1'b1;
                    end else if (!mask_on_next && known_len == 16'd0) begin
                        result.valid = 1'b1;
                        result.kind  = wsd_pkg::KIND_EMPTY;
                        result.last  = 1'b1;
                    end
                end
                wsd_pkg::PH_MASK: begin
                    if (count_inc >= wsd_pkg::MASK_KEY_BYTES && length_reg == 16'd0) begin
                        result.valid = 1'b1;
                        result.kind  = wsd_pkg::KIND_EMPTY;
                        result.last  = 1'b1;
                    end
                end
                wsd_pkg::PH_DATA: begin
                    result.valid        = 1'b1;
                    result.kind         = wsd_pkg::KIND_DATA;
                    result.data         = b ^ key_byte;
                    result.frame_length = length_reg;
                    result.last         = data_last;
                end
                default: begin
                    result.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= wsd_pkg::PH_HDR0;
            opcode_reg      <= 4'd0;
            mask_on_reg     <= 1'b0;
            length_reg      <= 16'd0;
            count_reg       <= 16'd0;
            key_reg         <= 32'd0;
            max_payload_reg <= wsd_pkg::MAX_PAYLOAD_RESET;
        end else begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            mask_on_reg <= mask_on_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            key_reg     <= key_next;
            if (cfg_wr_en) begin
                max_payload_reg <= cfg_wr_data;
            end
        end
    end

endmodule

/* hdl/wsd_out_stage.sv */
// Result register of the frame deframer: holds one result until it is taken.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  wsd_pkg::result_t result,
    output logic             can_load,
    output logic             m_valid,
    input  logic             m_ready,
    output wsd_pkg::result_t held
);

    logic             valid_reg, valid_next;
    wsd_pkg::result_t res_reg, res_next;

    // The register is free when empty or when its request is taken this cycle.
    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg && !m_ready;
        res_next   = res_reg;
        if (fire) begin
            valid_next = result.valid;
            if (result.valid) begin
                res_next = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

    assign m_valid = valid_reg;
    assign held    = res_reg;

endmodule

/* hdl/websocket_frame_deframer_core.sv */
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_in_stage, wsd_parser, wsd_out_stage and assert_macros.svh.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_wire_byte (one wire byte)
//   m_        out        m_valid/m_ready    kind, data, frame_opcode, frame_length,
//                                           error_code, last
//   cfg_      in         cfg_wr_en          cfg_wr_data (max_payload)
//
// One byte is accepted per cycle unless a stall on m_ready holds the flow. A taken byte
// sits in the input register while the parser updates the frame state, and any result
// loads into the result register at the same edge. Reset is synchronous on aresetn (low)
// and clears the valid flags and frame state; max_payload returns to 1024. A stall on
// m_ready holds the result register and, through it, the input register and s_ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module websocket_frame_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_wire_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_data,
    output logic [3:0]  m_frame_opcode,
    output logic [15:0] m_frame_length,
    output logic        m_error_code,
    output logic        m_last,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    wsd_pkg::in_item_t item;
    wsd_pkg::result_t  result;
    wsd_pkg::result_t  held;
    logic              can_load;
    logic              fire;

    // The parser works on the held byte whenever the result register can take it.
    assign fire = item.valid && can_load;

    wsd_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_wire_byte (s_wire_byte),
        .consume     (fire),
        .item        (item)
    );

    wsd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .item        (item),
        .result      (result)
    );

    wsd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .held     (held)
    );

    assign m_kind         = held.kind;
    assign m_data         = held.data;
    assign m_frame_opcode = held.frame_opcode;
    assign m_frame_length = held.frame_length;
    assign m_error_code   = held.error_code;
    assign m_last         = held.last;

    `ASSERT_IMPLY(a_error_is_last, aclk, aresetn, m_valid && m_kind == wsd_pkg::KIND_ERROR, m_last)
    `ASSERT_IMPLY(a_no_data_outside_payload, aclk, aresetn, m_valid && m_kind != wsd_pkg::KIND_DATA, m_data == 8'd0)
    `ASSERT_IMPLY(a_over_max_only_on_error, aclk, aresetn, m_valid && m_error_code, m_kind == wsd_pkg::KIND_ERROR)
    `ASSERT_NEXT(a_result_follows_fire, aclk, aresetn, fire && result.valid, m_valid && m_kind == $past(result.kind))

endmodule
